// File: rtl/lbwd_pkg.sv
// ----------------------------------------------------------------------------
// lbwd_pkg
// Shared widths, register indexes and types of the LED blink word decoder.
// ----------------------------------------------------------------------------
package lbwd_pkg;

  localparam int unsigned WORD_BITS  = 5;
  localparam int unsigned LEVEL_W    = 8;
  localparam int unsigned TAKEN_W    = $clog2(WORD_BITS + 1);
  localparam int unsigned TAG_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_RED_THRESHOLD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_LIFETIME  = 2'd2;

  localparam logic [LEVEL_W-1:0] RED_THRESHOLD_RST  = 8'd80;
  localparam logic [LEVEL_W-1:0] BLUE_THRESHOLD_RST = 8'd50;
  localparam logic [LEVEL_W-1:0] DARK_LIFETIME_RST  = 8'd60;
  localparam logic [LEVEL_W-1:0] DARK_MAX           = '1;

  typedef struct packed {
    logic [LEVEL_W-1:0] red_threshold;
    logic [LEVEL_W-1:0] blue_threshold;
    logic [LEVEL_W-1:0] dark_lifetime;
  } cfg_t;

  typedef struct packed {
    logic                 cursor_pressed;
    logic                 word_done;
    logic [WORD_BITS-1:0] word_value;
    logic                 id_known;
    logic [TAG_W-1:0]     id_out;
    logic                 color_known;
    logic [TAG_W-1:0]     color_out;
    logic                 track_lost;
  } result_t;

endpackage

// File: rtl/lbwd_if.sv
// ----------------------------------------------------------------------------
// lbwd_if
// Handshake channels of the LED blink word decoder: frame, result, config.
// ----------------------------------------------------------------------------
interface lbwd_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_level;
  logic [7:0] blue_level;

  modport source (output valid, output red_level, output blue_level, input ready);
  modport sink   (input valid, input red_level, input blue_level, output ready);
endinterface

interface lbwd_result_if;
  logic       valid;
  logic       ready;
  logic       cursor_pressed;
  logic       word_done;
  logic [4:0] word_value;
  logic       id_known;
  logic [1:0] id_out;
  logic       color_known;
  logic [1:0] color_out;
  logic       track_lost;

  modport source (output valid, output cursor_pressed, output word_done, output word_value,
                  output id_known, output id_out, output color_known, output color_out,
                  output track_lost, input ready);
  modport sink   (input valid, input cursor_pressed, input word_done, input word_value,
                  input id_known, input id_out, input color_known, input color_out,
                  input track_lost, output ready);
endinterface

interface lbwd_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/lbwd_cfg.sv
// ----------------------------------------------------------------------------
// lbwd_cfg
// Threshold and lifetime registers, written through the config channel.
// ----------------------------------------------------------------------------
module lbwd_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  lbwd_cfg_if.sink      cfg_i,
  output lbwd_pkg::cfg_t cfg_o
);
  import lbwd_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_RED_THRESHOLD:  cfg_d.red_threshold  = cfg_i.data;
        REG_BLUE_THRESHOLD: cfg_d.blue_threshold = cfg_i.data;
        REG_DARK_LIFETIME:  cfg_d.dark_lifetime  = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_threshold  <= RED_THRESHOLD_RST;
      cfg_q.blue_threshold <= BLUE_THRESHOLD_RST;
      cfg_q.dark_lifetime  <= DARK_LIFETIME_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/lbwd_in_stage.sv
// ----------------------------------------------------------------------------
// lbwd_in_stage
// Input register: holds one frame sample until the decoder takes it.
// ----------------------------------------------------------------------------
module lbwd_in_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lbwd_frame_if.sink                    frame_i,
  input  logic                          adv_i,
  output logic                          valid_o,
  output logic [lbwd_pkg::LEVEL_W-1:0]  red_o,
  output logic [lbwd_pkg::LEVEL_W-1:0]  blue_o
);
  import lbwd_pkg::*;

  logic               valid_q;
  logic [LEVEL_W-1:0] red_q;
  logic [LEVEL_W-1:0] blue_q;
  logic               take;

  assign frame_i.ready = !valid_q || adv_i;
  assign take          = frame_i.valid && frame_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (frame_i.ready) begin
      valid_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      red_q  <= frame_i.red_level;
      blue_q <= frame_i.blue_level;
    end
  end

  assign valid_o = valid_q;
  assign red_o   = red_q;
  assign blue_o  = blue_q;

endmodule

// File: rtl/lbwd_decode.sv
// ----------------------------------------------------------------------------
// lbwd_decode
// Receiver state and one-frame update: bit slicing, word shift, parity,
// id and color latching, dark frame count and track drop.
// ----------------------------------------------------------------------------
module lbwd_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lbwd_pkg::cfg_t                cfg_i,
  input  logic                          take_i,
  input  logic [lbwd_pkg::LEVEL_W-1:0]  red_i,
  input  logic [lbwd_pkg::LEVEL_W-1:0]  blue_i,
  output lbwd_pkg::result_t             result_o
);
  import lbwd_pkg::*;

  logic                 rx_q, rx_d;
  logic [WORD_BITS-1:0] shift_q, shift_d;
  logic [TAKEN_W-1:0]   taken_q, taken_d;
  logic [WORD_BITS-1:0] last_q, last_d;
  logic [LEVEL_W-1:0]   dark_q, dark_d;
  logic                 id_vld_q, id_vld_d;
  logic [TAG_W-1:0]     id_q, id_d;
  logic                 col_vld_q, col_vld_d;
  logic [TAG_W-1:0]     col_q, col_d;

  logic                 bit_on;
  logic                 done;
  logic                 lost;
  logic [WORD_BITS-1:0] word;
  logic [TAKEN_W-1:0]   taken_inc;
  logic [TAG_W-1:0]     tag;

  always_comb begin
    bit_on    = red_i > cfg_i.red_threshold;
    rx_d      = rx_q;
    shift_d   = shift_q;
    taken_d   = taken_q;
    last_d    = last_q;
    id_vld_d  = id_vld_q;
    id_d      = id_q;
    col_vld_d = col_vld_q;
    col_d     = col_q;
    done      = 1'b0;
    word      = {shift_q[WORD_BITS-2:0], bit_on};
    taken_inc = taken_q + TAKEN_W'(1);
    tag       = word[WORD_BITS-1 -: TAG_W];

    if (bit_on) begin
      dark_d = '0;
    end else if (dark_q != DARK_MAX) begin
      dark_d = dark_q + LEVEL_W'(1);
    end else begin
      dark_d = dark_q;
    end

    if (!rx_q) begin
      rx_d = bit_on;
    end else if (taken_inc >= TAKEN_W'(WORD_BITS)) begin
      rx_d    = 1'b0;
      shift_d = '0;
      taken_d = '0;
      last_d  = word;
      done    = 1'b1;
      if (!(^word)) begin
        if (!id_vld_q) begin
          id_vld_d = 1'b1;
          id_d     = tag;
        end
        if (id_d == tag) begin
          col_vld_d = 1'b1;
          col_d     = word[TAG_W:1];
        end
      end
    end else begin
      shift_d = word;
      taken_d = taken_inc;
    end

    lost = dark_d > cfg_i.dark_lifetime;
    if (lost) begin
      rx_d      = 1'b0;
      shift_d   = '0;
      taken_d   = '0;
      last_d    = '0;
      dark_d    = '0;
      id_vld_d  = 1'b0;
      id_d      = '0;
      col_vld_d = 1'b0;
      col_d     = '0;
    end

    result_o.cursor_pressed = blue_i > cfg_i.blue_threshold;
    result_o.word_done      = done;
    result_o.word_value     = last_d;
    result_o.id_known       = id_vld_d;
    result_o.id_out         = id_vld_d ? id_d : '0;
    result_o.color_known    = col_vld_d;
    result_o.color_out      = col_vld_d ? col_d : '0;
    result_o.track_lost     = lost;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_q      <= 1'b0;
      shift_q   <= '0;
      taken_q   <= '0;
      last_q    <= '0;
      dark_q    <= '0;
      id_vld_q  <= 1'b0;
      id_q      <= '0;
      col_vld_q <= 1'b0;
      col_q     <= '0;
    end else if (take_i) begin
      rx_q      <= rx_d;
      shift_q   <= shift_d;
      taken_q   <= taken_d;
      last_q    <= last_d;
      dark_q    <= dark_d;
      id_vld_q  <= id_vld_d;
      id_q      <= id_d;
      col_vld_q <= col_vld_d;
      col_q     <= col_d;
    end
  end

endmodule

// File: rtl/led_blink_word_decoder_top.sv
// ----------------------------------------------------------------------------
// led_blink_word_decoder_top
// Blink code decoder for one tracked LED, one frame sample per item.
//
//   channel   dir  handshake            payload
//   frame_i   in   valid / ready        red_level, blue_level
//   result_o  out  valid / ready        cursor_pressed .. track_lost
//   cfg_i     in   valid / ready (=1)   index, data
//
// An item goes from acceptance through the input register, then one pass
// of decode logic into the result register. While result_o.ready is high,
// one item per cycle is sustained; state registers update once per item.
// Reset clears the receiver state and loads the default thresholds.
// A stalled result holds the result register and then the input register;
// frame_i.ready drops only when both are full and result_o.ready is low.
// ----------------------------------------------------------------------------
module led_blink_word_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  lbwd_frame_if.sink  frame_i,
  lbwd_result_if.source result_o,
  lbwd_cfg_if.sink    cfg_i
);
  import lbwd_pkg::*;

  cfg_t               cfg;
  logic               s1_valid;
  logic [LEVEL_W-1:0] s1_red;
  logic [LEVEL_W-1:0] s1_blue;
  logic               adv;
  result_t            res_d;
  result_t            res_q;
  logic               out_valid_q;

  assign adv = s1_valid && (!out_valid_q || result_o.ready);

  lbwd_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  lbwd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame_i),
    .adv_i   (adv),
    .valid_o (s1_valid),
    .red_o   (s1_red),
    .blue_o  (s1_blue)
  );

  lbwd_decode u_decode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .take_i   (adv),
    .red_i    (s1_red),
    .blue_i   (s1_blue),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || result_o.ready) begin
      out_valid_q <= s1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.cursor_pressed = res_q.cursor_pressed;
  assign result_o.word_done      = res_q.word_done;
  assign result_o.word_value     = res_q.word_value;
  assign result_o.id_known       = res_q.id_known;
  assign result_o.id_out         = res_q.id_out;
  assign result_o.color_known    = res_q.color_known;
  assign result_o.color_out      = res_q.color_out;
  assign result_o.track_lost     = res_q.track_lost;

`ifndef NO_ASSERTIONS
  a_lost_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.track_lost) |->
      (res_q.word_value == '0 && !res_q.id_known && !res_q.color_known))
    else $error("dropped track left decoder state in the result");

  a_color_needs_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.color_known) |-> res_q.id_known)
    else $error("color reported without an identifier");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_i.valid && frame_i.ready) |=> s1_valid)
    else $error("accepted item missing from input register");

  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("decoded item missing from result register");
`endif

endmodule

// File: sim/tb_led_blink_word_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_led_blink_word_decoder_top
// Self-checking bench for the LED blink word decoder. Frames go in over the
// frame channel, and a software copy of the decoder works out each result
// as the frame is taken in. Results are compared field by field in order.
// The run covers directed words and parity cases, track drops (word and
// drop in one frame among them), a long result hold-off that fills the
// pipeline, a long dark stretch at a lifetime of 254, and random frame
// streams under several threshold settings with random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_led_blink_word_decoder_top;
  import lbwd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned DRAIN_CYCLES = 4;

  logic clk_i;
  logic rst_ni;

  lbwd_frame_if  frame_ch ();
  lbwd_result_if result_ch ();
  lbwd_cfg_if    cfg_ch ();

  led_blink_word_decoder_top u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (frame_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  // decoder copy: thresholds
  logic [LEVEL_W-1:0] red_thr   = RED_THRESHOLD_RST;
  logic [LEVEL_W-1:0] blue_thr  = BLUE_THRESHOLD_RST;
  logic [LEVEL_W-1:0] dark_life = DARK_LIFETIME_RST;

  // decoder copy: track state
  logic                 rx_active;
  logic [WORD_BITS-1:0] rx_shift;
  logic [TAKEN_W-1:0]   rx_count;
  logic [WORD_BITS-1:0] word_latched;
  logic [LEVEL_W-1:0]   dark_count;
  logic                 id_seen;
  logic [TAG_W-1:0]     id_tag;
  logic                 color_seen;
  logic [TAG_W-1:0]     color_tag;

  result_t pending_results[$];
  int      mismatches  = 0;
  int      frames_sent = 0;
  bit      frame_gaps  = 1'b0;
  bit      result_stalls = 1'b0;
  bit      hold_req    = 1'b0;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic void clear_track();
    rx_active    = 1'b0;
    rx_shift     = '0;
    rx_count     = '0;
    word_latched = '0;
    dark_count   = '0;
    id_seen      = 1'b0;
    id_tag       = '0;
    color_seen   = 1'b0;
    color_tag    = '0;
  endfunction

  function automatic result_t decode_frame(input logic [LEVEL_W-1:0] red,
                                           input logic [LEVEL_W-1:0] blue);
    result_t r;
    logic    lit;
    logic    done;
    logic    lost;
    lit  = red > red_thr;
    done = 1'b0;
    lost = 1'b0;
    if (!lit) begin
      if (dark_count != DARK_MAX) dark_count = dark_count + 1'b1;
    end else begin
      dark_count = '0;
    end
    if (!rx_active) begin
      if (lit) rx_active = 1'b1;
    end else begin
      rx_shift = {rx_shift[WORD_BITS-2:0], lit};
      rx_count = rx_count + 1'b1;
      if (rx_count >= WORD_BITS) begin
        rx_active    = 1'b0;
        word_latched = rx_shift;
        rx_shift     = '0;
        rx_count     = '0;
        done         = 1'b1;
        if (!(^word_latched)) begin
          if (!id_seen) begin
            id_seen = 1'b1;
            id_tag  = word_latched[4:3];
          end
          if (id_tag == word_latched[4:3]) begin
            color_seen = 1'b1;
            color_tag  = word_latched[2:1];
          end
        end
      end
    end
    if (dark_count > dark_life) begin
      clear_track();
      lost = 1'b1;
    end
    r.cursor_pressed = blue > blue_thr;
    r.word_done      = done;
    r.word_value     = word_latched;
    r.id_known       = id_seen;
    r.id_out         = id_seen ? id_tag : '0;
    r.color_known    = color_seen;
    r.color_out      = color_seen ? color_tag : '0;
    r.track_lost     = lost;
    return r;
  endfunction

  function automatic int unsigned gap_len();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(6, 25) : $urandom_range(1, 2);
  endfunction

  // mode 0: full-scale or zero level, mode 1: at or just above the threshold, else random
  function automatic logic [LEVEL_W-1:0] level_for(input logic on, input logic [LEVEL_W-1:0] thr,
                                                   input int unsigned mode);
    if (on) begin
      if (thr == DARK_MAX || mode == 0) return DARK_MAX;
      if (mode == 1) return thr + 1'b1;
      return LEVEL_W'($urandom_range(DARK_MAX, thr + 1));
    end
    if (mode == 0) return '0;
    if (mode == 1) return thr;
    return LEVEL_W'($urandom_range(thr, 0));
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_RED_THRESHOLD:  red_thr   = cfg_ch.data;
        REG_BLUE_THRESHOLD: blue_thr  = cfg_ch.data;
        REG_DARK_LIFETIME:  dark_life = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && frame_ch.valid && frame_ch.ready)
      pending_results.push_back(decode_frame(frame_ch.red_level, frame_ch.blue_level));
  end

  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result item with no expectation pending");
        mismatches++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("cursor_pressed", 32'(exp_r.cursor_pressed), 32'(result_ch.cursor_pressed));
        check_field("word_done", 32'(exp_r.word_done), 32'(result_ch.word_done));
        check_field("word_value", 32'(exp_r.word_value), 32'(result_ch.word_value));
        check_field("id_known", 32'(exp_r.id_known), 32'(result_ch.id_known));
        check_field("id_out", 32'(exp_r.id_out), 32'(result_ch.id_out));
        check_field("color_known", 32'(exp_r.color_known), 32'(result_ch.color_known));
        check_field("color_out", 32'(exp_r.color_out), 32'(result_ch.color_out));
        check_field("track_lost", 32'(exp_r.track_lost), 32'(result_ch.track_lost));
      end
    end
  end

  // result sink: random stalls, and a long hold-off on request
  initial begin
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        result_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (result_stalls && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap_len() - 1) @(posedge clk_i);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_frame(input logic [LEVEL_W-1:0] red, input logic [LEVEL_W-1:0] blue);
    if (frame_gaps && $urandom_range(0, 2) == 0) begin
      frame_ch.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
    frame_ch.valid      <= 1'b1;
    frame_ch.red_level  <= red;
    frame_ch.blue_level <= blue;
    do @(posedge clk_i); while (!frame_ch.ready);
    frames_sent++;
  endtask

  task automatic send_bit(input logic on, input int unsigned mode);
    send_frame(level_for(on, red_thr, mode), level_for(1'($urandom_range(0, 1)), blue_thr, mode));
  endtask

  task automatic send_word(input logic [WORD_BITS-1:0] w, input int unsigned mode);
    send_bit(1'b1, mode);
    for (int i = WORD_BITS - 1; i >= 0; i--) send_bit(w[i], mode);
  endtask

  task automatic send_dark(input int unsigned n);
    repeat (n) send_bit(1'b0, $urandom_range(0, 2));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  task automatic wait_drained();
    frame_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input logic [LEVEL_W-1:0] red, input logic [LEVEL_W-1:0] blue,
                           input logic [LEVEL_W-1:0] life);
    wait_drained();
    write_reg(REG_RED_THRESHOLD, red);
    write_reg(REG_BLUE_THRESHOLD, blue);
    write_reg(REG_DARK_LIFETIME, life);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 255)));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic test_directed_words();
    send_word(5'b10100, 0);
    send_word(5'b10101, 1);
    send_word(5'b01100, 2);
    send_word(5'b10010, 1);
  endtask

  task automatic test_track_drop();
    configure('0, DARK_MAX, 8'd2);
    send_dark(3);
    send_word(5'b11011, 0);
    send_word(5'b11000, 1);
    configure('0, DARK_MAX, '0);
    send_dark(1);
    send_word(5'b11111, 0);
    send_dark(1);
  endtask

  task automatic test_backpressure();
    configure(LEVEL_W'($urandom_range(0, 254)), LEVEL_W'($urandom_range(0, 255)), 8'd20);
    frame_gaps    = 1'b0;
    result_stalls = 1'b0;
    hold_req      = 1'b1;
    repeat (4) send_word(WORD_BITS'($urandom_range(0, 31)), 2);
  endtask

  task automatic test_long_dark();
    configure(8'd200, '0, 8'd254);
    send_word(5'b01010, 0);
    send_dark(256);
    configure(DARK_MAX, DARK_MAX, 8'd254);
    repeat (20) send_frame(LEVEL_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 255)));
  endtask

  task automatic test_random_mix(input logic [LEVEL_W-1:0] red, input logic [LEVEL_W-1:0] blue,
                                 input logic [LEVEL_W-1:0] life, input int unsigned n);
    int unsigned          stop_at;
    logic [WORD_BITS-1:0] w;
    configure(red, blue, life);
    frame_gaps    = 1'b1;
    result_stalls = 1'b1;
    stop_at       = frames_sent + n;
    while (frames_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          w = WORD_BITS'($urandom_range(0, 31));
          if ($urandom_range(0, 1)) w[4:3] = id_tag;
          if ($urandom_range(0, 3) != 0) w[0] = ^w[4:1];
          send_word(w, $urandom_range(0, 2));
        end
        6, 7: send_frame(LEVEL_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 255)));
        8: send_dark($urandom_range(1, (life < 16) ? life + 3 : 20));
        default: begin
          send_bit(1'b1, 2);
          repeat ($urandom_range(1, 4)) send_bit(1'($urandom_range(0, 1)), 2);
          send_frame(LEVEL_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 255)));
        end
      endcase
    end
  endtask

  initial begin
    clear_track();
    rst_ni              <= 1'b0;
    frame_ch.valid      <= 1'b0;
    frame_ch.red_level  <= '0;
    frame_ch.blue_level <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= '0;
    cfg_ch.data         <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_words();
    test_track_drop();
    test_backpressure();
    test_long_dark();
    test_random_mix('0, '0, LEVEL_W'($urandom_range(0, 3)), 25);
    test_random_mix(LEVEL_W'($urandom_range(1, 254)), LEVEL_W'($urandom_range(1, 254)),
                    LEVEL_W'($urandom_range(4, 30)), 25);
    test_random_mix(LEVEL_W'($urandom_range(1, 254)), DARK_MAX,
                    LEVEL_W'($urandom_range(0, 254)), 25);

    wait_drained();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

// File: led_blink_word_decoder_top.f
rtl/lbwd_pkg.sv
rtl/lbwd_if.sv
rtl/lbwd_cfg.sv
rtl/lbwd_in_stage.sv
rtl/lbwd_decode.sv
rtl/led_blink_word_decoder_top.sv
sim/tb_led_blink_word_decoder_top.sv
